// ===== sv/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 decoder
package u8u16_pkg;

  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned STATUS_W = 3;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // end status codes
  localparam logic [STATUS_W-1:0] ST_RUN   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NUL   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STRAY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic                unit_valid;
    logic [UNIT_W-1:0]   code_unit;
    logic                string_done;
    logic [COUNT_W-1:0]  unit_count;
    logic [STATUS_W-1:0] end_status;
  } out_item_t;

endpackage

// ===== sv/utf8_to_utf16_decoder_core.sv =====
// top level of the utf-8 to utf-16 decoder
//
// Takes a utf-8 string one byte per item on the in_ channel and gives
// 16-bit basic-plane code units on the out_ channel. An item is accepted
// when valid is high and stall is low. A byte gives a result when it
// completes a unit or when it is marked last; the last byte's result
// carries string_done, the unit count and the end status.
// Each accepted byte is registered in the input register, then decoded
// into the output register.
// Throughput: one byte per cycle while out_stall is low, set by the
// single decode step between the input register and the output register.
// When the receiver stalls, the output register holds its result and
// in_stall rises only if the input register also holds a byte waiting
// to be decoded.
// The cfg_ channel writes output_limit and is always ready; write it
// only while no string is in flight.
// Reset (synchronous, rst_n low) empties both registers, clears the
// string state and sets output_limit to 65535.
module utf8_to_utf16_decoder_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u8u16_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u8u16_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [u8u16_pkg::COUNT_W-1:0] cfg_data
);
  import u8u16_pkg::*;

  logic               s1_valid_r;
  in_item_t           s1_item_r;
  logic [COUNT_W-1:0] limit_r;
  logic               ob_free;
  logic               fire;
  logic               res_valid;
  out_item_t          res_item;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid_r && ob_free;
  assign in_stall  = s1_valid_r && !ob_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      limit_r    <= LIMIT_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  u8u16_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item_r),
    .limit     (limit_r),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  u8u16_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (fire && res_valid),
    .load_item  (res_item),
    .free       (ob_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule

// ===== sv/u8u16_dec.sv =====
// per-string decode state and the byte decode logic
module u8u16_dec (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  u8u16_pkg::in_item_t         item,
  input  logic [u8u16_pkg::COUNT_W-1:0] limit,
  output logic                        res_valid,
  output u8u16_pkg::out_item_t        res_item
);
  import u8u16_pkg::*;

  logic [1:0]          need_r, need_nxt;
  logic [2:0]          skip_r, skip_nxt;
  logic [UNIT_W-1:0]   part_r, part_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] stop_r, stop_nxt;

  logic              emit;
  logic [UNIT_W-1:0] unit;
  logic [7:0]        b;
  logic [COUNT_W-1:0] cnt_upd;
  logic [STATUS_W-1:0] status;

  always_comb begin
    b         = item.in_byte;
    need_nxt  = need_r;
    skip_nxt  = skip_r;
    part_nxt  = part_r;
    stop_nxt  = stop_r;
    emit      = 1'b0;
    unit      = '0;
    if (stop_r == ST_RUN) begin
      if (need_r != 2'd0) begin
        if (need_r == 2'd2) begin
          part_nxt = part_r | {4'd0, b[5:0], 6'd0};
        end else begin
          part_nxt = part_r | {10'd0, b[5:0]};
        end
        need_nxt = need_r - 2'd1;
        if (need_nxt == 2'd0) begin
          emit     = 1'b1;
          unit     = part_nxt;
          part_nxt = '0;
        end
      end else if (skip_r != 3'd0) begin
        skip_nxt = skip_r - 3'd1;
      end else if (b == 8'h00) begin
        stop_nxt = ST_NUL;
      end else if (cnt_r >= limit) begin
        stop_nxt = ST_LIMIT;
      end else if (b < 8'h80) begin
        emit = 1'b1;
        unit = {8'd0, b};
      end else if (b < 8'hC0) begin
        stop_nxt = ST_STRAY;
      end else if (b < 8'hE0) begin
        part_nxt = {5'd0, b[4:0], 6'd0};
        need_nxt = 2'd1;
      end else if (b < 8'hF0) begin
        part_nxt = {b[3:0], 12'd0};
        need_nxt = 2'd2;
      end else if (b < 8'hF8) begin
        skip_nxt = 3'd3;
      end else if (b < 8'hFC) begin
        skip_nxt = 3'd4;
      end else begin
        skip_nxt = 3'd5;
      end
    end

    cnt_upd = emit ? cnt_r + 16'd1 : cnt_r;
    cnt_nxt = cnt_upd;

    status = ST_RUN;
    if (item.in_last) begin
      if (stop_nxt != ST_RUN) begin
        status = stop_nxt;
      end else if (need_nxt != 2'd0 || skip_nxt != 3'd0) begin
        status = ST_TRUNC;
      end
      // string ends: clear everything for the next one
      need_nxt = '0;
      skip_nxt = '0;
      part_nxt = '0;
      cnt_nxt  = '0;
      stop_nxt = ST_RUN;
    end

    res_valid            = emit | item.in_last;
    res_item.unit_valid  = emit;
    res_item.code_unit   = unit;
    res_item.string_done = item.in_last;
    res_item.unit_count  = cnt_upd;
    res_item.end_status  = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= '0;
      skip_r <= '0;
      part_r <= '0;
      cnt_r  <= '0;
      stop_r <= ST_RUN;
    end else if (fire) begin
      need_r <= need_nxt;
      skip_r <= skip_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ===== sv/u8u16_obuf.sv =====
// result register toward the output channel
module u8u16_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_valid,
  input  u8u16_pkg::out_item_t load_item,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  // register can take a new result when empty or being drained this cycle
  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load_valid) begin
      item_r <= load_item;
    end
  end

endmodule

// ===== sv/u8u16_chk.sv =====
// port-level checks for the decoder top level
module u8u16_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input u8u16_pkg::out_item_t out_item
);
  import u8u16_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input backpressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // a result that does not end a string must carry a unit
  a_mid_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.string_done |-> out_item.unit_valid)
    else $error("empty result in mid string");

  // status only reported on the string's last result
  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.string_done |-> out_item.end_status == ST_RUN)
    else $error("end status before string end");

endmodule

bind utf8_to_utf16_decoder_core u8u16_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
